>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define LSH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define LSH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/lsh_pkg.sv
package lsh_pkg;

    localparam int LSH_MAX_LINE_WIDTH = 2048;
    localparam int FRAME_HEIGHT_MAX   = 4096;

    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W          = 12;

    localparam int WIDTH_MIN  = 3;
    localparam int HEIGHT_MIN = 3;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // 5*centre minus four neighbours spans -1020..1275
    localparam int SHARP_W = 12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] pixel_t;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } lsh_reg_t;

    typedef struct packed
    {
        pixel_t above;
        pixel_t two_above;
    } line_pair_t;

    typedef struct packed
    {
        pixel_t pixel_out;
        logic   run_last;
        logic   frame_end;
    } lsh_result_t;

    typedef struct packed
    {
        logic [1:0]  cnt;
        lsh_result_t first;
        lsh_result_t second;
    } lsh_push_t;

endpackage

>>> hw/rtl/lsh_if.sv
interface lsh_in_if import lsh_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_in;
    logic   frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface lsh_out_if import lsh_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   run_last;
    logic   frame_end;

    modport source (output valid, output pixel_out, output run_last, output frame_end,
                    input ready);
    modport sink (input valid, input pixel_out, input run_last, input frame_end,
                  output ready);
endinterface

>>> hw/rtl/lsh_line_mem.sv
module lsh_line_mem import lsh_pkg::*;
#(
    parameter int DEPTH = LSH_MAX_LINE_WIDTH,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output line_pair_t    rd_data_a,
    output line_pair_t    rd_data_b,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_pair_t    wr_data
);

    line_pair_t mem [DEPTH];
    line_pair_t rd_a_reg;
    line_pair_t rd_b_reg;
    line_pair_t wr_hold_reg;
    logic       fwd_a_reg;
    logic       fwd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // bypass for a read that meets a write to the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_a_reg   <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg   <= wr_en && (wr_addr == rd_addr_b);
            wr_hold_reg <= wr_data;
        end
    end

    assign rd_data_a = fwd_a_reg ? wr_hold_reg : rd_a_reg;
    assign rd_data_b = fwd_b_reg ? wr_hold_reg : rd_b_reg;

endmodule

>>> hw/rtl/lsh_out_queue.sv
`include "assert_macros.svh"

module lsh_out_queue import lsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lsh_push_t          push,
    input  logic               pop,
    output lsh_result_t        head,
    output logic               not_empty,
    output logic [LEVEL_W-1:0] level
);

    lsh_result_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  wr_ptr_inc;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               pop_ok;

    assign not_empty  = (level_reg != '0);
    assign pop_ok     = pop && not_empty;
    assign head       = slot_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop_ok);
        level_next  = level_reg + LEVEL_W'(push.cnt) - LEVEL_W'(pop_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            slot_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    `LSH_ASSERT_NEVER(a_queue_overflow, clk, rst_n, 32'(level_reg) > QUEUE_DEPTH, "result queue overflow")

endmodule

>>> hw/rtl/laplacian_sharpen_3x3.sv
// 3x3 cross laplacian sharpen for 8-bit grayscale frames
// in_ch takes one pixel per transfer in raster order, frame_start on the first
// pixel of a frame; out_ch gives the sharpened frame one row behind the input
// frame size is set over the apb port (frame_width at 0x0, frame_height at 0x4)
// and the user must write it only while the stream is idle, which the block does not enforce; pready is always high
// a pixel of row r gives the result for row r-1 at the same column; row 0 gives
// nothing and each pixel of the last row gives two results (its row above and
// the zero border pixel of the last row itself)
// a result passes the s1 registers and then the result queue before out_ch can take it
// throughput: one pixel per cycle while the queue has room; on the last row the
// single output port carries two results per pixel, so in_ch.ready drops at times
// both line rows sit in one dual read port memory of depth MAX_LINE_WIDTH, read
// in the accept cycle and written back in the cycle after it, with bypass
// reset puts the position at row 0 column 0 and the size at 640 x 480; the line
// memory is not cleared, the first two rows of a frame fill it
// results wait in a four entry queue; when the receiver stalls the queue fills
// and in_ch.ready drops once less than two free slots remain
`include "assert_macros.svh"

module laplacian_sharpen_3x3 import lsh_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = LSH_MAX_LINE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lsh_in_if.sink                in_ch,
    lsh_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    lsh_reg_t                  reg_idx;
    logic [WW-1:0]             eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;

    logic [AW-1:0]             col_reg;
    logic [AW-1:0]             col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;

    logic [AW-1:0]             col_base;
    logic [ROW_W-1:0]          row_base;
    logic [AW-1:0]             cur_col;
    logic [FRAME_HEIGHT_W-1:0] cur_row;
    logic [WW-1:0]             col_inc;
    logic                      last_col;
    logic                      last_row;
    logic                      interior;
    logic [1:0]                res_cnt;
    logic                      in_accept;

    logic                      s1_valid_reg;
    logic [AW-1:0]             s1_col_reg;
    pixel_t                    s1_pix_reg;
    logic [1:0]                s1_cnt_reg;
    logic                      s1_interior_reg;
    logic                      s1_corner_reg;
    pixel_t                    prev_centre_reg;

    line_pair_t                rd_a;
    line_pair_t                rd_b;
    line_pair_t                wr_pair;
    pixel_t                    centre;
    logic [SHARP_W-1:0]        acc;
    pixel_t                    sat;
    pixel_t                    sharp;

    lsh_push_t                 push;
    lsh_result_t               head;
    logic                      q_not_empty;
    logic [LEVEL_W-1:0]        q_level;
    logic [1:0]                pend;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = lsh_reg_t'(paddr[APB_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
        endcase
    end

    // size kept at least three and limited to what the line memory and row counter hold
    always_comb
    begin
        priority if (frame_width_reg < FRAME_WIDTH_W'(WIDTH_MIN))
        begin
            eff_w = WW'(WIDTH_MIN);
        end
        else if (32'(frame_width_reg) > 32'(MAX_LINE_WIDTH))
        begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end

        priority if (frame_height_reg < FRAME_HEIGHT_W'(HEIGHT_MIN))
        begin
            eff_h = FRAME_HEIGHT_W'(HEIGHT_MIN);
        end
        else if (32'(frame_height_reg) > 32'(FRAME_HEIGHT_MAX))
        begin
            eff_h = FRAME_HEIGHT_W'(FRAME_HEIGHT_MAX);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    // position of the incoming pixel
    always_comb
    begin
        col_base = in_ch.frame_start ? '0 : col_reg;
        row_base = in_ch.frame_start ? '0 : row_reg;
        cur_col  = col_base;
        cur_row  = FRAME_HEIGHT_W'(row_base);
        if (WW'(col_base) >= eff_w)
        begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        if (cur_row >= eff_h)
        begin
            cur_row = '0;
        end

        col_inc  = WW'(cur_col) + 1'b1;
        last_col = (col_inc == eff_w);
        last_row = ((cur_row + 1'b1) == eff_h);
        interior = (cur_row >= FRAME_HEIGHT_W'(2)) && (cur_col != '0) && (col_inc < eff_w);

        priority if (cur_row == '0)
        begin
            res_cnt = 2'd0;
        end
        else if (last_row)
        begin
            res_cnt = 2'd2;
        end
        else
        begin
            res_cnt = 2'd1;
        end

        col_next = last_col ? '0 : AW'(col_inc);
        if (last_col)
        begin
            row_next = last_row ? '0 : ROW_W'(cur_row + 1'b1);
        end
        else
        begin
            row_next = ROW_W'(cur_row);
        end
    end

    // room for two more results beyond those already queued or in flight
    assign pend        = s1_valid_reg ? s1_cnt_reg : 2'd0;
    assign in_ch.ready = ((LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(pend))
                         <= (LEVEL_W + 1)'(QUEUE_DEPTH - 2);
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg      <= cur_col;
            s1_pix_reg      <= in_ch.pixel_in;
            s1_cnt_reg      <= res_cnt;
            s1_interior_reg <= interior;
            s1_corner_reg   <= last_col;
        end
        if (s1_valid_reg)
        begin
            prev_centre_reg <= centre;
        end
    end

    lsh_line_mem #(
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .rd_en     (in_accept),
        .rd_addr_a (cur_col),
        .rd_addr_b (AW'(col_inc)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_col_reg),
        .wr_data   (wr_pair)
    );

    // stencil: left neighbour is the centre of the previous column
    always_comb
    begin
        centre = rd_a.above;
        wr_pair.above     = s1_pix_reg;
        wr_pair.two_above = centre;

        acc = (SHARP_W'(centre) << 2) + SHARP_W'(centre)
              - SHARP_W'(prev_centre_reg) - SHARP_W'(rd_b.above)
              - SHARP_W'(rd_a.two_above) - SHARP_W'(s1_pix_reg);

        priority if (acc[SHARP_W-1])
        begin
            sat = '0;
        end
        else if (acc[SHARP_W-2:8] != '0)
        begin
            sat = '1;
        end
        else
        begin
            sat = acc[7:0];
        end
        sharp = s1_interior_reg ? sat : '0;

        push.cnt              = s1_valid_reg ? s1_cnt_reg : 2'd0;
        push.first.pixel_out  = sharp;
        push.first.run_last   = (s1_cnt_reg != 2'd2);
        push.first.frame_end  = 1'b0;
        push.second.pixel_out = '0;
        push.second.run_last  = 1'b1;
        push.second.frame_end = s1_corner_reg;
    end

    lsh_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ch.ready),
        .head      (head),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    assign out_ch.valid     = q_not_empty;
    assign out_ch.pixel_out = head.pixel_out;
    assign out_ch.run_last  = head.run_last;
    assign out_ch.frame_end = head.frame_end;

    `LSH_ASSERT(a_interior_col, clk, rst_n, s1_valid_reg && s1_interior_reg |-> s1_col_reg != '0, "interior pixel on first column")
    `LSH_ASSERT(a_end_is_last, clk, rst_n, out_ch.valid && out_ch.frame_end |-> out_ch.run_last, "frame end not last of its run")
    `LSH_ASSERT(a_push_room, clk, rst_n, s1_valid_reg |-> 32'(q_level) + 32'(s1_cnt_reg) <= QUEUE_DEPTH, "results pushed without room")

endmodule
